@@ design/bpdae_pkg.sv @@
// Package for the buffer pool directory: default sizes, command and status
// codes, and the control word that the sequencer hands to the scan unit.
// No dependencies.
package bpdae_pkg;

  localparam int NUM_ENTRIES_DEF     = 32;
  localparam int NUM_DISK_BLOCKS_DEF = 8192;
  localparam int AGE_BITS_DEF        = 16;

  localparam int CMD_W    = 2;
  localparam int BLKIN_W  = 16;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DIRTY  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOB   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTIN = 2'd2;

  // One step of the directory scan.
  typedef struct packed {
    logic clear;        // start of a new command
    logic step;         // entry data present this cycle
    logic alloc;        // allocate scan, else lookup scan
    logic entry_valid;  // valid flag of the entry being scanned
  } scan_ctl_t;

endpackage

@@ design/buffer_pool_directory_age_evict.sv @@
// Buffer pool directory with age-based replacement, one command at a time.
// Out-of-bound commands skip the scan and go straight to the result state. Others
// scan every entry through the shared scan unit, one entry per cycle from the age
// and block RAMs, then pass through a finishing state and a result state; a new
// command is taken only once the last result word has been loaded into the output.
// Synchronous reset clears all entries to free and clean; no clearing pass.
module buffer_pool_directory_age_evict
  import bpdae_pkg::*;
#(
  parameter int NUM_ENTRIES     = NUM_ENTRIES_DEF,
  parameter int NUM_DISK_BLOCKS = NUM_DISK_BLOCKS_DEF,
  parameter int AGE_BITS        = AGE_BITS_DEF,
  localparam int IW = $clog2(NUM_ENTRIES),
  localparam int BW = $clog2(NUM_DISK_BLOCKS),
  localparam int DW = ((STATUS_W + IW + 1 + BW + 7) / 8) * 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [23:0]   s_tdata,   // command[1:0], block_number[17:2], zero fill
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [DW-1:0] m_tdata    // status, entry_index, writeback_valid,
                                   // writeback_block, zero fill
);

  localparam int CW = $clog2(NUM_ENTRIES + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_FINISH = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t state;

  logic [NUM_ENTRIES-1:0] valid;
  logic [NUM_ENTRIES-1:0] dirty;

  logic [CMD_W-1:0]   req_cmd;
  logic [BW-1:0]      req_blk;
  logic [CW-1:0]      cnt;
  logic               rd_vld;
  logic [IW-1:0]      rd_idx;

  logic [STATUS_W-1:0] res_status;
  logic [IW-1:0]       res_index;
  logic                res_wbv;
  logic [BW-1:0]       res_wbb;

  logic [STATUS_W-1:0] out_status;
  logic [IW-1:0]       out_index;
  logic                out_wbv;
  logic [BW-1:0]       out_wbb;

  logic [CMD_W-1:0]   in_cmd;
  logic [BLKIN_W-1:0] in_blk;
  logic               accept;
  logic               in_oob;
  logic               is_alloc;
  logic               scan_done;
  logic               issue;
  logic               out_free;
  logic               load_out;

  logic [AGE_BITS-1:0] age_rd;
  logic [BW-1:0]       blk_rd;
  logic [AGE_BITS-1:0] aged;
  logic                age_we;
  logic [IW-1:0]       age_waddr;
  logic [AGE_BITS-1:0] age_wdata;
  logic                blk_we;

  scan_ctl_t     ctl;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic [IW-1:0] old_idx;
  logic [BW-1:0] old_block;
  logic          hit;
  logic [IW-1:0] hit_idx;
  logic [IW-1:0] chosen;

  assign in_cmd   = s_tdata[1:0];
  assign in_blk   = s_tdata[17:2];
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_oob   = ({1'b0, in_blk} >= (BLKIN_W + 1)'(NUM_DISK_BLOCKS));
  assign is_alloc = (req_cmd == CMD_ALLOC);
  assign issue    = (state == S_SCAN) && (cnt != CW'(NUM_ENTRIES));
  assign scan_done = (state == S_SCAN) && (cnt == CW'(NUM_ENTRIES)) && rd_vld;
  assign out_free = !m_tvalid || m_tready;
  assign load_out = (state == S_DONE) && out_free;
  assign chosen   = free_found ? free_idx : old_idx;

  assign ctl.clear       = accept;
  assign ctl.step        = (state == S_SCAN) && rd_vld;
  assign ctl.alloc       = is_alloc;
  assign ctl.entry_valid = valid[rd_idx];

  // During an allocate scan, ages go back one entry behind the read; the loaded
  // entry gets age zero in the finishing cycle.
  always_comb begin
    age_we    = 1'b0;
    age_waddr = rd_idx;
    age_wdata = aged;
    if (ctl.step && is_alloc) begin
      age_we = 1'b1;
    end else if ((state == S_FINISH) && is_alloc) begin
      age_we    = 1'b1;
      age_waddr = chosen;
      age_wdata = '0;
    end
  end

  assign blk_we = (state == S_FINISH) && is_alloc;

  bpdae_ram #(.WIDTH(AGE_BITS), .DEPTH(NUM_ENTRIES)) u_age_ram (
    .clk     (clk),
    .wr_en   (age_we),
    .wr_addr (age_waddr),
    .wr_data (age_wdata),
    .rd_en   (issue),
    .rd_addr (cnt[IW-1:0]),
    .rd_data (age_rd)
  );

  bpdae_ram #(.WIDTH(BW), .DEPTH(NUM_ENTRIES)) u_blk_ram (
    .clk     (clk),
    .wr_en   (blk_we),
    .wr_addr (chosen),
    .wr_data (req_blk),
    .rd_en   (issue),
    .rd_addr (cnt[IW-1:0]),
    .rd_data (blk_rd)
  );

  bpdae_scan_unit #(.IW(IW), .BW(BW), .AW(AGE_BITS)) u_scan (
    .clk        (clk),
    .ctl        (ctl),
    .idx        (rd_idx),
    .age_in     (age_rd),
    .block_in   (blk_rd),
    .key        (req_blk),
    .aged       (aged),
    .free_found (free_found),
    .free_idx   (free_idx),
    .old_idx    (old_idx),
    .old_block  (old_block),
    .hit        (hit),
    .hit_idx    (hit_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      valid    <= '0;
      dirty    <= '0;
      cnt      <= '0;
      rd_vld   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req_cmd <= in_cmd;
            req_blk <= in_blk[BW-1:0];
            cnt     <= '0;
            rd_vld  <= 1'b0;
            if (in_oob) begin
              res_status <= ST_OOB;
              res_index  <= '0;
              res_wbv    <= 1'b0;
              res_wbb    <= '0;
              state      <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rd_vld <= issue;
          if (issue) begin
            rd_idx <= cnt[IW-1:0];
            cnt    <= cnt + CW'(1);
          end
          if (scan_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (is_alloc) begin
            valid[chosen] <= 1'b1;
            dirty[chosen] <= 1'b0;
            res_status    <= ST_OK;
            res_index     <= chosen;
            if (!free_found && dirty[old_idx]) begin
              res_wbv <= 1'b1;
              res_wbb <= old_block;
            end else begin
              res_wbv <= 1'b0;
              res_wbb <= '0;
            end
          end else if (hit) begin
            res_status <= ST_OK;
            res_index  <= hit_idx;
            res_wbv    <= 1'b0;
            res_wbb    <= '0;
            if (req_cmd == CMD_DIRTY) begin
              dirty[hit_idx] <= 1'b1;
            end
          end else begin
            res_status <= ST_NOTIN;
            res_index  <= '0;
            res_wbv    <= 1'b0;
            res_wbb    <= '0;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_status <= res_status;
            out_index  <= res_index;
            out_wbv    <= res_wbv;
            out_wbb    <= res_wbb;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = DW'({out_wbb, out_wbv, out_index, out_status});

  // A failed command reports neither an entry nor a write-back.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_status != ST_OK)) |-> ((out_index == '0) && !out_wbv))
    else $error("failed command reports an entry or a write-back");

  // An allocation leaves the chosen entry occupied and clean.
  assert property (@(posedge clk) disable iff (rst)
    ((state == S_FINISH) && is_alloc) |=> (valid[$past(chosen)] && !dirty[$past(chosen)]))
    else $error("allocated entry not loaded");

  // A write-back only comes from an eviction, and an eviction only happens when every entry is full.
  assert property (@(posedge clk) disable iff (rst)
    ((state == S_FINISH) && is_alloc && !free_found) |-> (valid == '1))
    else $error("eviction while a free entry exists");

  // The scan counter never runs past the directory.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (cnt <= CW'(NUM_ENTRIES)))
    else $error("scan counter overrun");

  // The result waits in S_DONE until the output register frees up.
  assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && !out_free) |=> (state == S_DONE))
    else $error("result dropped while output stalled");

endmodule

@@ design/bpdae_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bpdae_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/bpdae_scan_unit.sv @@
// Shared scan unit: ages one entry per step and keeps the running results of
// the scan (lowest free entry, oldest entry, first matching entry).
// Depends on bpdae_pkg.
module bpdae_scan_unit
  import bpdae_pkg::*;
#(
  parameter int IW = 5,
  parameter int BW = 13,
  parameter int AW = 16
) (
  input  logic            clk,
  input  scan_ctl_t       ctl,
  input  logic [IW-1:0]   idx,
  input  logic [AW-1:0]   age_in,
  input  logic [BW-1:0]   block_in,
  input  logic [BW-1:0]   key,
  output logic [AW-1:0]   aged,
  output logic            free_found,
  output logic [IW-1:0]   free_idx,
  output logic [IW-1:0]   old_idx,
  output logic [BW-1:0]   old_block,
  output logic            hit,
  output logic [IW-1:0]   hit_idx
);

  logic [AW-1:0] old_age;
  logic          take_old;
  logic          match;

  // Saturating age increment for occupied entries.
  assign aged = (ctl.entry_valid && (age_in != {AW{1'b1}})) ? age_in + AW'(1) : age_in;

  // Greater-or-equal lets the highest index win a tie.
  assign take_old = ctl.entry_valid && (aged >= old_age);
  assign match    = ctl.entry_valid && (block_in == key);

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      free_found <= 1'b0;
      hit        <= 1'b0;
      old_age    <= '0;
      free_idx   <= '0;
      old_idx    <= '0;
      old_block  <= '0;
      hit_idx    <= '0;
    end else if (ctl.step) begin
      if (ctl.alloc) begin
        if (!ctl.entry_valid && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= idx;
        end
        if (take_old) begin
          old_age   <= aged;
          old_idx   <= idx;
          old_block <= block_in;
        end
      end else if (match && !hit) begin
        hit     <= 1'b1;
        hit_idx <= idx;
      end
    end
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for the buffer pool directory: streams allocate, lookup and mark-dirty
// commands into the block and checks every result word against a shadow directory.
// Depends on bpdae_pkg and buffer_pool_directory_age_evict.
module tb_top;
  import bpdae_pkg::*;

  localparam int N_SLOTS = NUM_ENTRIES_DEF;
  localparam int N_DISK  = NUM_DISK_BLOCKS_DEF;
  localparam int AGE_W   = AGE_BITS_DEF;
  localparam int SLOT_W  = $clog2(N_SLOTS);
  localparam int BLK_W   = $clog2(N_DISK);
  localparam int OUT_W   = ((STATUS_W + SLOT_W + 1 + BLK_W + 7) / 8) * 8;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam logic [AGE_W-1:0] AGE_TOP = '1;
  localparam int N_RANDOM    = 2000;
  localparam int WORK_SET    = 40;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = N_SLOTS + 8;

  // Fields of one result word, lowest bits last in the declaration.
  typedef struct packed {
    logic [BLK_W-1:0]    wb_block;
    logic                wb_valid;
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status;
  } dir_result_t;
  localparam int RES_W = $bits(dir_result_t);

  // Shadow copy of the directory plus the queue of results still owed by the block.
  class directory_shadow;
    bit                 valid  [N_SLOTS];
    bit                 dirty  [N_SLOTS];
    logic [BLK_W-1:0]   blk_of [N_SLOTS];
    logic [AGE_W-1:0]   age    [N_SLOTS];
    dir_result_t        owed_results [$];
    int errors, checked;
    int n_alloc, n_evict, n_writeback, n_hit, n_miss, n_oob;

    function new();
      foreach (valid[i]) begin
        valid[i]  = 1'b0;
        dirty[i]  = 1'b0;
        blk_of[i] = '0;
        age[i]    = '0;
      end
      errors = 0;
      checked = 0;
      n_alloc = 0;
      n_evict = 0;
      n_writeback = 0;
      n_hit = 0;
      n_miss = 0;
      n_oob = 0;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // Applies one accepted command to the shadow and queues the result it must produce.
    function void note_command(logic [CMD_W-1:0] cmd, logic [BLKIN_W-1:0] blk);
      dir_result_t r;
      int chosen;
      int oldest;
      int hit;
      r = '0;
      if (blk >= N_DISK) begin
        r.status = ST_OOB;
        n_oob++;
      end else if (cmd == CMD_ALLOC) begin
        n_alloc++;
        chosen = -1;
        oldest = 0;
        for (int i = 0; i < N_SLOTS; i++)
          if (valid[i] && age[i] != AGE_TOP) age[i] = age[i] + 1'b1;
        // First free entry wins; otherwise the oldest, with ties going to the higher index.
        for (int i = 0; i < N_SLOTS; i++) begin
          if (chosen < 0) begin
            if (!valid[i]) chosen = i;
            else if (age[i] >= age[oldest]) oldest = i;
          end
        end
        if (chosen < 0) begin
          chosen = oldest;
          n_evict++;
          if (dirty[chosen]) begin
            r.wb_valid = 1'b1;
            r.wb_block = blk_of[chosen];
            n_writeback++;
          end
        end
        valid[chosen]  = 1'b1;
        dirty[chosen]  = 1'b0;
        blk_of[chosen] = blk[BLK_W-1:0];
        age[chosen]    = '0;
        r.status = ST_OK;
        r.slot   = chosen[SLOT_W-1:0];
      end else begin
        // Lookup, mark dirty and the spare code all search for the lowest matching entry.
        hit = -1;
        for (int i = N_SLOTS - 1; i >= 0; i--)
          if (valid[i] && blk_of[i] == blk[BLK_W-1:0]) hit = i;
        if (hit < 0) begin
          r.status = ST_NOTIN;
          n_miss++;
        end else begin
          r.status = ST_OK;
          r.slot   = hit[SLOT_W-1:0];
          n_hit++;
          if (cmd == CMD_DIRTY) dirty[hit] = 1'b1;
        end
      end
      owed_results.push_back(r);
    endfunction

    function void check_result(logic [OUT_W-1:0] word);
      dir_result_t got;
      dir_result_t want;
      got = word[RES_W-1:0];
      checked++;
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: result word %h arrived with nothing expected", $time, word);
      end else begin
        want = owed_results.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: result mismatch: expected status=%0d entry=%0d wb=%0d wb_block=%0d",
                   $time, want.status, want.slot, want.wb_valid, want.wb_block);
          $display("%0t:                  actual status=%0d entry=%0d wb=%0d wb_block=%0d",
                   $time, got.status, got.slot, got.wb_valid, got.wb_block);
        end
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [23:0]      s_tdata = '0;  // command[1:0], block_number[17:2], zero fill
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;       // status, entry_index, writeback_valid,
                                   // writeback_block, zero fill

  directory_shadow  board;
  logic [BLK_W-1:0] work_set [WORK_SET];
  int               hold_left = 0;

  always #4 clk = ~clk;

  buffer_pool_directory_age_evict DUT (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata
  );

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [BLKIN_W-1:0] blk);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, blk, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_command(cmd, blk);
  endtask

  task automatic pause_sender(input int gap);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_sender();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Mostly well-formed traffic on a small working set so the pool fills, evicts and
  // writes back; the rest is out-of-bound blocks and fully random words.
  task automatic random_item(output logic [CMD_W-1:0] cmd, output logic [BLKIN_W-1:0] blk);
    int pick;
    int kind;
    pick = $urandom_range(0, 99);
    if (pick < 5) work_set[$urandom_range(0, WORK_SET - 1)] = BLK_W'($urandom_range(0, N_DISK - 1));
    if (pick < 80) begin
      kind = $urandom_range(0, 9);
      cmd  = (kind < 4) ? CMD_ALLOC : ((kind < 7) ? CMD_LOOKUP : CMD_DIRTY);
      blk  = BLKIN_W'(work_set[$urandom_range(0, WORK_SET - 1)]);
    end else if (pick < 90) begin
      cmd = CMD_W'($urandom_range(0, 3));
      blk = BLKIN_W'($urandom_range(N_DISK, 65535));
    end else begin
      cmd = CMD_W'($urandom_range(0, 3));
      blk = BLKIN_W'($urandom_range(0, 65535));
    end
  endtask

  // The receiver alternates short ready and stall runs, with occasional long ready stretches.
  always @(negedge clk) begin
    if (hold_left == 0) begin
      if ($urandom_range(0, 9) == 0) begin
        m_tready  <= 1'b1;
        hold_left <= $urandom_range(300, 600);
      end else if (m_tready) begin
        m_tready  <= 1'b0;
        hold_left <= $urandom_range(1, 30);
      end else begin
        m_tready  <= 1'b1;
        hold_left <= $urandom_range(1, 40);
      end
    end else begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    int               sent;
    int               burst_len;
    int               gap;
    bit               drained;
    logic [CMD_W-1:0] cmd;
    logic [BLKIN_W-1:0] blk;
    board = new();
    sent = 0;
    drained = 1'b0;
    foreach (work_set[i]) work_set[i] = BLK_W'($urandom_range(0, N_DISK - 1));
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty directory, the block number extremes, duplicates and the spare code.
    send_word(CMD_LOOKUP, 16'd0);
    send_word(CMD_DIRTY,  16'd5);
    send_word(CMD_ALLOC,  16'd0);
    send_word(CMD_ALLOC,  16'd8191);
    send_word(CMD_ALLOC,  16'd8192);
    send_word(CMD_LOOKUP, 16'hFFFF);
    send_word(CMD_DIRTY,  16'hFFFF);
    send_word(CMD_ALLOC,  16'hFFFF);
    send_word(CMD_SPARE,  16'hE000);
    send_word(CMD_LOOKUP, 16'd8191);
    send_word(CMD_DIRTY,  16'd8191);
    send_word(CMD_SPARE,  16'd0);
    send_word(CMD_SPARE,  16'h1555);
    send_word(CMD_ALLOC,  16'd0);
    send_word(CMD_LOOKUP, 16'd0);
    send_word(CMD_DIRTY,  16'd0);
    send_word(CMD_ALLOC,  16'h0AAA);
    send_word(CMD_ALLOC,  16'h1555);
    send_word(CMD_LOOKUP, 16'h1555);
    send_word(CMD_DIRTY,  16'h1234);
    send_word(CMD_LOOKUP, 16'h2000);
    pause_sender($urandom_range(1, 40));

    while (sent < N_RANDOM) begin
      burst_len = $urandom_range(1, 12);
      for (int k = 0; k < burst_len; k++) begin
        random_item(cmd, blk);
        send_word(cmd, blk);
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
      pause_sender(gap);
      if (!drained && sent >= N_RANDOM / 2) begin
        drain_sender();
        drained = 1'b1;
      end
    end

    drain_sender();
    repeat (SETTLE) @(posedge clk);
    $display("Run covered %0d results: %0d allocations, %0d evictions, %0d write-backs,",
             board.checked, board.n_alloc, board.n_evict, board.n_writeback);
    $display("%0d hits, %0d misses and %0d out-of-bound commands; %0d errors.",
             board.n_hit, board.n_miss, board.n_oob, board.errors);
    if (board.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/bpdae_pkg.sv
design/bpdae_ram.sv
design/bpdae_scan_unit.sv
design/buffer_pool_directory_age_evict.sv
dv/tb_top.sv
